/* rtl/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Shared codes, sequencer states and the compare-unit control group.
// ----------------------------------------------------------------------------
package fpba_pkg;

	// Fixed widths of the channel fields
	localparam int AMOUNT_W = 16;
	localparam int INDEX_W  = 5;
	localparam int FUNC_W   = 2;
	localparam int POLICY_W = 2;

	// Item function codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Policy codes; any other code behaves as next fit
	localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} fpba_state_t;

	// Control group for the shared compare unit
	typedef struct packed {
		logic best;   // smallest fitting entry wins
		logic worst;  // largest fitting entry wins
		logic found;  // a candidate is already held
	} fpba_cmp_ctl_t;

endpackage

/* rtl/fpba_mem.sv */
// ----------------------------------------------------------------------------
// Block size table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fpba_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/fpba_cmp.sv */
// ----------------------------------------------------------------------------
// Fit compare unit
// Decides whether the entry just read fits and replaces the held candidate.
// ----------------------------------------------------------------------------
module fpba_cmp
	import fpba_pkg::*;
#(
	parameter int DW = 16
) (
	input  fpba_cmp_ctl_t ctl,
	input  logic [DW-1:0] req,
	input  logic [DW-1:0] entry,
	input  logic [DW-1:0] held,
	output logic          fits,
	output logic          take
);

	always_comb begin
		fits = (req <= entry);
		take = fits && (!ctl.found
			|| (ctl.best && (entry < held))
			|| (ctl.worst && (entry > held)));
	end

endmodule

/* rtl/fit_policy_block_allocator.sv */
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Free-block table searched by next-fit, best-fit or worst-fit policy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, func, amount) carries one transaction
//   per item: load appends a block size, clear empties the table and the
//   rotating pointer, allocate searches the table. Loads into a full table
//   and unused function codes are dropped without a result.
//   Output channel (out_valid/out_stall, granted, block_index, remaining)
//   carries one transaction per allocate item.
//   policy_we/policy_wdata writes the policy register; write it while idle.
// Timing:
//   Loads and clears finish while idle. An allocate reads the loaded
//   entries one per cycle through the single table read port and one shared
//   compare unit, and stops early when next fit hits; an empty table skips
//   the reads. in_stall stays high from an accepted allocate until its result
//   enters the output register.
// Reset clears the table count, the pointer, the policy and the output
// valid; table contents stay undefined until loaded.
// A stalled result waits in the output register; the block still takes
// loads and clears, and a following allocate holds at its end until the
// earlier result has gone.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
	import fpba_pkg::*;
#(
	parameter int NUM_BLOCKS = 32,
	parameter int SIZE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                policy_we,
	input  logic [POLICY_W-1:0] policy_wdata,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [AMOUNT_W-1:0] amount,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                granted,
	output logic [INDEX_W-1:0]  block_index,
	output logic [AMOUNT_W-1:0] remaining
);

	localparam int AW    = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int DW    = SIZE_BITS;

	fpba_state_t state_q, state_d;

	logic [POLICY_W-1:0] policy_q;
	logic [CNT_W-1:0]    count_q;
	logic [AW-1:0]       ptr_q;

	// search registers
	logic [DW-1:0]    req_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] issue_left_q;
	logic [CNT_W-1:0] cmp_left_q;
	logic             rd_valid_s1;
	logic [AW-1:0]    addr_s1;
	logic             found_q;
	logic [AW-1:0]    best_idx_q;
	logic [DW-1:0]    best_size_q;

	// output register
	logic                out_valid_q;
	logic                granted_q;
	logic [INDEX_W-1:0]  index_q;
	logic [AMOUNT_W-1:0] remaining_q;

	// table ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic          mem_re;
	logic [DW-1:0] mem_rdata;

	logic          in_accept;
	logic          next_fit;
	logic          is_best;
	logic          is_worst;
	logic          fits;
	logic          take;
	logic          scan_end;
	logic          finish;
	logic [AW-1:0] start_addr;
	logic [AW-1:0] addr_next;
	logic [DW-1:0] amt;
	logic [DW-1:0] left;
	logic [AW+INDEX_W-1:0]  idx_ext;
	logic [DW+AMOUNT_W-1:0] amt_ext;
	logic [DW+AMOUNT_W-1:0] left_ext;
	fpba_cmp_ctl_t cmp_ctl;

	// Take amount modulo 2^SIZE_BITS, widening when the table is wider.
	assign amt_ext = {{DW{1'b0}}, amount};
	assign amt     = amt_ext[DW-1:0];

	assign is_best  = (policy_q == POL_BEST);
	assign is_worst = (policy_q == POL_WORST);
	assign next_fit = !is_best && !is_worst;

	assign in_accept = in_valid && !in_stall;

	// Next fit resumes at the pointer unless it fell past the table end.
	assign start_addr = (next_fit && (CNT_W'(ptr_q) < count_q)) ? ptr_q : '0;
	assign addr_next  = (CNT_W'(addr_q) == count_q - CNT_W'(1)) ? '0 : addr_q + AW'(1);

	assign cmp_ctl = '{best: is_best, worst: is_worst, found: found_q};

	fpba_cmp #(
		.DW (DW)
	) u_cmp (
		.ctl   (cmp_ctl),
		.req   (req_q),
		.entry (mem_rdata),
		.held  (best_size_q),
		.fits  (fits),
		.take  (take)
	);

	fpba_mem #(
		.DEPTH (NUM_BLOCKS),
		.AW    (AW),
		.DW    (DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// Stop after the last entry, or at the first hit under next fit.
	assign scan_end = rd_valid_s1 && ((cmp_left_q == CNT_W'(1)) || (next_fit && fits));
	// Retire only once the output register is free.
	assign finish   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign left     = best_size_q - req_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && (func == FUNC_ALLOC)) begin
					state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = 1'b1;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = left;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				// append a loaded size while there is room
				if (in_accept && (func == FUNC_LOAD) && (count_q < CNT_W'(NUM_BLOCKS))) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[AW-1:0];
					mem_wdata = amt;
				end
			end
			ST_SCAN: begin
				mem_re = (issue_left_q != '0);
			end
			ST_DONE: begin
				// write back the shrunk block
				mem_we = finish && found_q;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_NEXT;
		end else if (policy_we) begin
			policy_q <= policy_wdata;
		end
	end

	// table count and rotating pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (in_accept && (func == FUNC_CLEAR)) begin
				count_q <= '0;
				ptr_q   <= '0;
			end else if (in_accept && (func == FUNC_LOAD) && (count_q < CNT_W'(NUM_BLOCKS))) begin
				count_q <= count_q + CNT_W'(1);
			end
			// advance the pointer past a next-fit grant, wrapping at the end
			if (finish && found_q && next_fit) begin
				ptr_q <= (CNT_W'(best_idx_q) + CNT_W'(1) < count_q) ? best_idx_q + AW'(1) : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				rd_valid_s1 <= 1'b0;
				if (in_accept && (func == FUNC_ALLOC)) begin
					found_q <= 1'b0;
				end
			end else if (state_q == ST_SCAN) begin
				rd_valid_s1 <= mem_re;
				if (rd_valid_s1 && take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (in_accept && (func == FUNC_ALLOC)) begin
			req_q        <= amt;
			addr_q       <= start_addr;
			issue_left_q <= count_q;
			cmp_left_q   <= count_q;
		end else if (state_q == ST_SCAN) begin
			if (mem_re) begin
				addr_q       <= addr_next;
				issue_left_q <= issue_left_q - CNT_W'(1);
			end
			addr_s1 <= addr_q;
			if (rd_valid_s1) begin
				cmp_left_q <= cmp_left_q - CNT_W'(1);
				if (take) begin
					best_idx_q  <= addr_s1;
					best_size_q <= mem_rdata;
				end
			end
		end
	end

	assign idx_ext  = {{INDEX_W{1'b0}}, best_idx_q};
	assign left_ext = {{AMOUNT_W{1'b0}}, left};

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			granted_q   <= found_q;
			index_q     <= found_q ? idx_ext[INDEX_W-1:0] : '0;
			remaining_q <= found_q ? left_ext[AMOUNT_W-1:0] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = granted_q;
	assign block_index = index_q;
	assign remaining   = remaining_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_BLOCKS))
		else $error("table count beyond capacity");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q != '0))
		else $error("search running on an empty table");

	a_pick_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && found_q) |-> (CNT_W'(best_idx_q) < count_q))
		else $error("chosen block outside the loaded entries");

	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && found_q) |-> (req_q <= best_size_q))
		else $error("chosen block smaller than the request");

	a_cmp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rd_valid_s1) |-> (cmp_left_q != '0))
		else $error("compare past the last loaded entry");

endmodule

/* dv/fpba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy allocator checker
// Tracks the free-block table from accepted transactions, predicts each
// allocate answer and compares it with the result channel.
// ----------------------------------------------------------------------------
module fpba_checker
	import fpba_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                policy_we,
	input  logic [POLICY_W-1:0] policy_wdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [AMOUNT_W-1:0] amount,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                granted,
	input  logic [INDEX_W-1:0]  block_index,
	input  logic [AMOUNT_W-1:0] remaining,
	output int                  fail_count,
	output int                  pending
);

	localparam int TABLE_DEPTH = 32;

	typedef struct packed {
		logic                granted;
		logic [INDEX_W-1:0]  index;
		logic [AMOUNT_W-1:0] rest;
	} grant_t;

	grant_t              grants_due[$];
	logic [AMOUNT_W-1:0] free_size[TABLE_DEPTH];
	int                  free_count;
	int                  rover;
	logic [POLICY_W-1:0] policy;

	// Pick a block by the current policy, take the request out of it
	function automatic grant_t allocate(input logic [AMOUNT_W-1:0] req);
		grant_t g;
		int     pick;
		int     pos;
		bit     hit;
		g    = '0;
		pick = 0;
		hit  = 1'b0;
		if (policy == POL_BEST || policy == POL_WORST) begin
			for (int i = 0; i < free_count; i++) begin
				if (req <= free_size[i] && (!hit ||
						(policy == POL_BEST && free_size[i] < free_size[pick]) ||
						(policy == POL_WORST && free_size[i] > free_size[pick]))) begin
					pick = i;
					hit  = 1'b1;
				end
			end
		end else begin
			pos = (rover < free_count) ? rover : 0;
			for (int i = 0; i < free_count && !hit; i++) begin
				if (req <= free_size[pos]) begin
					pick = pos;
					hit  = 1'b1;
				end else begin
					pos = (pos + 1 >= free_count) ? 0 : pos + 1;
				end
			end
		end
		if (hit) begin
			free_size[pick] = free_size[pick] - req;
			if (policy != POL_BEST && policy != POL_WORST)
				rover = (pick + 1 < free_count) ? pick + 1 : 0;
			g.granted = 1'b1;
			g.index   = pick[INDEX_W-1:0];
			g.rest    = free_size[pick];
		end
		return g;
	endfunction

	task automatic flag(input string what, input grant_t want, input grant_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected granted=%0d index=%0d remaining=%0d, %s%0d %s%0d %s%0d",
				$realtime, what, want.granted, want.index, want.rest,
				"got granted=", got.granted, "index=", got.index,
				"remaining=", got.rest);
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t got;
		grant_t want;
		if (!arst_n) begin
			policy     = POL_NEXT;
			free_count = 0;
			rover      = 0;
			grants_due.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			// retire the oldest expectation before queuing a new one
			if (out_valid && !out_stall) begin
				got = '{granted, block_index, remaining};
				if (grants_due.size() == 0) begin
					flag("result with no allocate outstanding", '0, got);
				end else begin
					want = grants_due.pop_front();
					if (got !== want)
						flag("allocate result mismatch", want, got);
				end
			end
			if (policy_we)
				policy = policy_wdata;
			if (in_valid && !in_stall) begin
				case (func)
					FUNC_LOAD: begin
						if (free_count < TABLE_DEPTH) begin
							free_size[free_count] = amount;
							free_count++;
						end
					end
					FUNC_ALLOC: grants_due.push_back(allocate(amount));
					FUNC_CLEAR: begin
						free_count = 0;
						rover      = 0;
					end
					default: ;
				endcase
			end
			pending = grants_due.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator testbench
// Drives load, allocate and clear transactions under every policy setting,
// with random idling on both channels, a long result back-pressure stretch
// and drained policy changes; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module testbench
	import fpba_pkg::*;
;

	// Unused codes, exercised on purpose
	localparam logic [FUNC_W-1:0]   FUNC_SPARE = 2'd3;
	localparam logic [POLICY_W-1:0] POL_SPARE  = 2'd3;

	// Settle time after draining; longer than a full-table search
	localparam int SETTLE    = 48;
	localparam int LONG_HOLD = 300;
	localparam int ITEMS     = 1250;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                policy_we    = 1'b0;
	logic [POLICY_W-1:0] policy_wdata = '0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func         = FUNC_LOAD;
	logic [AMOUNT_W-1:0] amount       = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic                granted;
	logic [INDEX_W-1:0]  block_index;
	logic [AMOUNT_W-1:0] remaining;

	int fail_count;
	int pending;
	int fed       = 0;   // transactions sent, unused codes not counted
	bit quiet     = 1'b0; // no idling on either side once set
	bit hold_go   = 1'b0;
	bit hold_done = 1'b0;

	always #2 clk = ~clk;

	fit_policy_block_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.policy_we    (policy_we),
		.policy_wdata (policy_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.amount       (amount),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.block_index  (block_index),
		.remaining    (remaining)
	);

	fpba_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.policy_we    (policy_we),
		.policy_wdata (policy_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.amount       (amount),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.block_index  (block_index),
		.remaining    (remaining),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Hard stop in case the block hangs
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	// Every branch that drives out_stall ends on an edge, and the loop head waits on
	// an edge as well, so out_stall gets at most one update per step.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				// hold off long enough for results to back up into the input
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one transaction and return at the edge that accepts it.
	// Hold the payload steady for as long as the block stalls.
	task automatic send(input logic [FUNC_W-1:0] f, input logic [AMOUNT_W-1:0] a);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		amount   <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f != FUNC_SPARE)
			fed++;
	endtask

	// Stop offering, wait out every expected result, then let a trailing
	// load or clear finish before anything else happens.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Change the policy only with the block idle
	task automatic set_policy(input logic [POLICY_W-1:0] p);
		drain();
		policy_we    <= 1'b1;
		policy_wdata <= p;
		@(posedge clk);
		policy_we    <= 1'b0;
	endtask

	// Mostly sizes up to the span, with the field extremes and full-range
	// values mixed in
	function automatic logic [AMOUNT_W-1:0] pick_size(input int span);
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return '1;
			2:       return AMOUNT_W'($urandom);
			default: return AMOUNT_W'($urandom_range(0, span));
		endcase
	endfunction

	// One well-formed sequence: usually a clear, then fill part or all of the table, then
	// mostly allocates with some stray loads, clears and unused codes.
	task automatic run_episode();
		int span;
		int loads;
		int ops;
		int roll;
		case ($urandom_range(0, 2))
			0:       span = 60;
			1:       span = 1500;
			default: span = 65535;
		endcase
		if ($urandom_range(0, 7) != 0)
			send(FUNC_CLEAR, AMOUNT_W'($urandom));
		// now and then overfill so the table-full drop gets exercised
		loads = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
		repeat (loads) send(FUNC_LOAD, pick_size(span));
		ops = $urandom_range(4, 24);
		repeat (ops) begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				send(FUNC_LOAD, pick_size(span));
			else if (roll == 1)
				send(FUNC_SPARE, AMOUNT_W'($urandom));
			else if (roll == 2)
				send(FUNC_CLEAR, AMOUNT_W'($urandom));
			else
				send(FUNC_ALLOC, pick_size(span / 3));
		end
	endtask

	initial begin
		logic [POLICY_W-1:0] plan[7];
		int                  target;
		plan = '{POL_BEST, POL_WORST, POL_SPARE, POL_NEXT, POL_WORST, POL_BEST, POL_NEXT};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: next fit out of reset
		send(FUNC_ALLOC, 16'd0);        // empty table, no grant
		send(FUNC_LOAD, 16'd0);
		send(FUNC_LOAD, 16'hFFFF);
		send(FUNC_LOAD, 16'd100);
		send(FUNC_SPARE, 16'hFFFF);     // ignored, no result
		send(FUNC_ALLOC, 16'd0);        // zero request fits the zero block
		send(FUNC_ALLOC, 16'hFFFF);     // exact fit, nothing left
		send(FUNC_ALLOC, 16'd200);      // miss, pointer stays put
		send(FUNC_ALLOC, 16'd100);      // grant at the last entry, pointer wraps
		send(FUNC_ALLOC, 16'd1);        // every block is empty now
		send(FUNC_LOAD, 16'hAAAA);
		send(FUNC_LOAD, 16'h5555);
		send(FUNC_ALLOC, 16'h5555);
		send(FUNC_CLEAR, 16'hFFFF);
		send(FUNC_ALLOC, 16'd1);        // cleared table, no grant
		send(FUNC_LOAD, 16'd7);
		send(FUNC_ALLOC, 16'd7);

		// Random phases, one per entry of the policy plan; the last one runs without idling
		foreach (plan[p]) begin
			set_policy(plan[p]);
			if (p == 1)
				hold_go <= 1'b1;
			if (p == 6)
				quiet = 1'b1;
			target = fed + (ITEMS - 17) / 7;
			while (fed < target)
				run_episode();
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
